### src/dsc_pkg.sv
// Shared types and constants for the dual serial controller with mouse receiver.
// Holds the request and response structs, opcodes, command codes and register indexes.
// Depends on nothing; every other file imports it.
`default_nettype none

package dsc_pkg;

  // Default depth of each channel's receive FIFO
  localparam int DEFAULT_RX_FIFO_DEPTH = 3;

  // Bus operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ACK   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Channel select (port bit 1)
  localparam logic CH_A = 1'b0;
  localparam logic CH_B = 1'b1;

  // Write register indexes
  localparam logic [2:0] REG_0 = 3'd0;
  localparam logic [2:0] REG_1 = 3'd1;
  localparam logic [2:0] REG_2 = 3'd2;
  localparam logic [2:0] REG_3 = 3'd3;
  localparam logic [2:0] REG_5 = 3'd5;

  // WR0 command field, bits 5:3
  localparam logic [2:0] CMD_CHAN_RESET = 3'd3;
  localparam logic [2:0] CMD_NEXT_RX    = 3'd4;
  localparam logic [2:0] CMD_ERR_RESET  = 3'd6;

  // WR1 receive interrupt mode, bits 4:3
  localparam logic [1:0] RX_MODE_OFF  = 2'b00;
  localparam logic [1:0] RX_MODE_ONCE = 2'b01;

  // Interrupt line offsets within a channel
  localparam logic [1:0] LINE_RX      = 2'd2;
  localparam logic [1:0] LINE_SPECIAL = 2'd3;

  // Request payload
  typedef struct packed {
    op_t                opcode;
    logic [1:0]         port;
    logic [7:0]         write_data;
    logic [2:0]         ack_line;
    logic [1:0]         mouse_buttons;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] irq_lines;
  } rsp_t;

  // Three-byte mouse packet, byte 0 first
  typedef logic [2:0][7:0] mouse_pkt_t;

endpackage

`default_nettype wire

### src/dsc_mouse_pack.sv
// Mouse packet builder: buttons plus saturated movement bytes.
// Depends on dsc_pkg for the packet type.
`default_nettype none

module dsc_mouse_pack (
  input  wire logic [1:0]         buttons,
  input  wire logic signed [15:0] dx,
  input  wire logic signed [15:0] dy,
  output dsc_pkg::mouse_pkt_t     pkt
);
  import dsc_pkg::*;

  logic [7:0] b0, b1, b2;

  // Clamp each axis to one byte and flag overflow in byte 0
  always_comb begin
    b0 = {6'd0, buttons};
    if (dx > 16'sd127) begin
      b1 = 8'h7f;
      b0 = b0 | 8'h10;
    end else if (dx < -16'sd127) begin
      b1 = 8'h80;
      b0 = b0 | 8'h20;
    end else begin
      b1 = dx[7:0];
    end
    if (dy > 16'sd127) begin
      b2 = 8'h7f;
      b0 = b0 | 8'h40;
    end else if (dy < -16'sd127) begin
      b2 = 8'h80;
      b0 = b0 | 8'h80;
    end else begin
      b2 = dy[7:0];
    end
  end

  // Byte 0 sits in the low slot
  assign pkt = {b2, b1, b0};

endmodule

`default_nettype wire

### src/dsc_core.sv
// Register file and request decode of the dual serial controller.
// Holds WR/RR registers, pointers, receive FIFOs and interrupt pending bits.
// Depends on dsc_pkg.
`default_nettype none

module dsc_core #(
  parameter int RX_FIFO_DEPTH = dsc_pkg::DEFAULT_RX_FIFO_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire dsc_pkg::req_t        req,
  input  wire dsc_pkg::mouse_pkt_t  pkt,
  input  wire logic                 mouse_connected,
  output dsc_pkg::rsp_t             rsp
);
  import dsc_pkg::*;

  localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);

  logic [1:0][7:0][7:0]                   wr, wr_next;
  logic [1:0][2:0][7:0]                   rr, rr_next;
  logic [1:0][2:0]                        ptr, ptr_next;
  logic [1:0][RX_FIFO_DEPTH-1:0][7:0]     fifo, fifo_next;
  logic [1:0][CNT_W-1:0]                  cnt, cnt_next;
  logic [1:0]                             nrx, nrx_next;
  logic [7:0]                             irq, irq_next;

  logic       ch;
  logic [2:0] cur_ptr;
  logic [7:0] rdata;
  logic [2:0] hi_line;
  logic       any_pending;
  logic [7:0] vec_base;
  logic [7:0] pend_vec;
  logic [7:0] ack_vec;

  // Find the highest pending line for the vector scan
  always_comb begin
    hi_line     = 3'd0;
    any_pending = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (irq[i]) begin
        hi_line     = 3'(i);
        any_pending = 1'b1;
      end
    end
  end

  // Vectors come from channel B WR2, modified when status-affected mode is on
  always_comb begin
    vec_base = wr[CH_B][REG_2] & 8'hf1;
    if (!wr[CH_B][REG_1][2]) begin
      pend_vec = wr[CH_B][REG_2];
      ack_vec  = wr[CH_B][REG_2];
    end else begin
      pend_vec = any_pending ? (vec_base | {4'd0, hi_line, 1'b0}) : (vec_base | 8'h06);
      ack_vec  = vec_base | {4'd0, req.ack_line, 1'b0};
    end
  end

  // Decode one request into next state and read data
  always_comb begin
    wr_next   = wr;
    rr_next   = rr;
    ptr_next  = ptr;
    fifo_next = fifo;
    cnt_next  = cnt;
    nrx_next  = nrx;
    irq_next  = irq;
    rdata     = 8'd0;
    ch        = req.port[1];
    cur_ptr   = ptr[ch];

    unique case (req.opcode)
      OP_WRITE: begin
        if (req.port[0]) begin
          wr_next[ch][cur_ptr] = req.write_data;
          if (cur_ptr == REG_0) begin
            ptr_next[ch] = req.write_data[2:0];
            unique case (req.write_data[5:3])
              CMD_CHAN_RESET: begin
                for (int i = 0; i < 4; i++) begin
                  irq_next[{~ch, 2'(i)}] = 1'b0;
                end
                wr_next[ch]    = '0;
                rr_next[ch][0] = (rr[ch][0] & 8'h28) | 8'h04;
                rr_next[ch][1] = (rr[ch][0] & 8'h28) | 8'h04;
                rr_next[ch][2] = 8'd0;
              end
              CMD_NEXT_RX: begin
                nrx_next[ch] = 1'b1;
              end
              CMD_ERR_RESET: begin
                rr_next[ch][0] = rr[ch][0] & 8'h2f;
                rr_next[ch][1] = rr[ch][1] & 8'h01;
              end
              default: begin
              end
            endcase
          end else begin
            ptr_next[ch] = REG_0;
            // Rising RTS on channel B: flush receiver and, if WR3 bit 0 is set, queue a mouse packet
            if (ch == CH_B && cur_ptr == REG_5 && req.write_data[1] && !wr[CH_B][REG_5][1])
            begin
              fifo_next[CH_B]    = '0;
              cnt_next[CH_B]     = '0;
              nrx_next[CH_B]     = 1'b0;
              rr_next[CH_B][0][0] = 1'b0;
              rr_next[CH_B][1][5] = 1'b0;
              irq_next[{1'b0, LINE_RX}]      = 1'b0;
              irq_next[{1'b0, LINE_SPECIAL}] = 1'b0;
              if (wr[CH_B][REG_3][0]) begin
                fifo_next[CH_B][0]  = pkt[0];
                fifo_next[CH_B][1]  = pkt[1];
                fifo_next[CH_B][2]  = pkt[2];
                cnt_next[CH_B]      = CNT_W'(3);
                rr_next[CH_B][0][0] = 1'b1;
                if (wr[CH_B][REG_1][4]) begin
                  irq_next[{1'b0, LINE_RX}] = 1'b1;
                end
              end
            end
          end
        end else if (wr[ch][REG_3][3]) begin
          // Load transmit holding: TX buffer no longer empty
          rr_next[ch][0][2] = 1'b0;
        end
      end

      OP_READ: begin
        if (req.port[0]) begin
          // Status read; channel B reflects modem lines and live vector
          if (ch == CH_B) begin
            rr_next[CH_B][0] = mouse_connected ? (rr[CH_B][0] & ~8'h28)
                                               : (rr[CH_B][0] | 8'h28);
            if (cur_ptr == REG_2) begin
              rr_next[CH_B][2] = pend_vec;
            end
          end
          unique case (cur_ptr)
            REG_0:   rdata = rr_next[ch][0];
            REG_1:   rdata = rr_next[ch][1];
            REG_2:   rdata = rr_next[ch][2];
            default: rdata = 8'd0;
          endcase
          ptr_next[ch] = REG_0;
        end else begin
          // Pop the receive FIFO head
          rdata = fifo[ch][0];
          for (int i = 0; i < RX_FIFO_DEPTH - 1; i++) begin
            fifo_next[ch][i] = fifo[ch][i + 1];
          end
          if (cnt[ch] != '0) begin
            cnt_next[ch] = cnt[ch] - 1'b1;
          end
          if (cnt_next[ch] == '0) begin
            rr_next[ch][0][0] = 1'b0;
          end else if (wr[ch][REG_1][4:3] == RX_MODE_ONCE) begin
            if (nrx[ch]) begin
              nrx_next[ch] = 1'b0;
              irq_next[{~ch, LINE_RX}] = 1'b1;
            end
          end else if (wr[ch][REG_1][4:3] != RX_MODE_OFF) begin
            irq_next[{~ch, LINE_RX}] = 1'b1;
          end
        end
      end

      OP_ACK: begin
        rdata = ack_vec;
        irq_next[req.ack_line] = 1'b0;
      end

      OP_NONE: begin
      end
    endcase
  end

  assign rsp = '{read_data: rdata, irq_lines: irq_next};

  // Commit state on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      wr   <= '0;
      rr   <= '0;
      ptr  <= '0;
      fifo <= '0;
      cnt  <= '0;
      nrx  <= '0;
      irq  <= '0;
    end else if (step) begin
      wr   <= wr_next;
      rr   <= rr_next;
      ptr  <= ptr_next;
      fifo <= fifo_next;
      cnt  <= cnt_next;
      nrx  <= nrx_next;
      irq  <= irq_next;
    end
  end

endmodule

`default_nettype wire

### src/dual_serial_controller_with_mouse_rx_unit.sv
// Dual serial controller with mouse receiver: input register, decode core, output register.
// Uses dsc_pkg, dsc_mouse_pack and dsc_core.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one bus write, bus read or
//   interrupt acknowledge per request. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns exactly one response per request: read data (0 for writes) and
//   the eight pending interrupt bits after that request.
//   cfg_wr_en/cfg_wr_data write the mouse_connected bit; write it only idle.
// Path: an accepted request is held in the input register and decoded from it;
//   its response is registered in the output register once that register is free.
// Throughput: one request per cycle while responses are taken; the register and FIFO
//   update of each request is committed as it is decoded, so the next request sees it.
// Reset: rst (synchronous) clears all core registers, FIFOs, pointers, pending bits
//   and valid flags, and sets mouse_connected to 1. No clearing pass is needed.
// Stall: while rsp is held with rsp_ready low, one more request is taken
//   into the input register, then req_ready drops until the response leaves.
`default_nettype none

module dual_serial_controller_with_mouse_rx_unit #(
  parameter int RX_FIFO_DEPTH = dsc_pkg::DEFAULT_RX_FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire dsc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output dsc_pkg::rsp_t      rsp
);
  import dsc_pkg::*;

  logic       mouse_connected;
  logic       s1_valid;
  req_t       s1_req;
  logic       s1_advance;
  mouse_pkt_t pkt;
  rsp_t       core_rsp;

  // Hold the configuration bit
  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_connected <= 1'b1;
    end else if (cfg_wr_en) begin
      mouse_connected <= cfg_wr_data;
    end
  end

  // Advance the input register whenever the output register is free
  assign s1_advance = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready  = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_req <= '0;
    end else if (req_ready && req_valid) begin
      s1_req <= req;
    end
  end

  dsc_mouse_pack u_mouse_pack (
    .buttons (s1_req.mouse_buttons),
    .dx      (s1_req.mouse_dx),
    .dy      (s1_req.mouse_dy),
    .pkt     (pkt)
  );

  dsc_core #(
    .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (s1_advance),
    .req             (s1_req),
    .pkt             (pkt),
    .mouse_connected (mouse_connected),
    .rsp             (core_rsp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp <= core_rsp;
    end
  end

  // Input side stalls only behind a held response
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (s1_valid && rsp_valid && !rsp_ready))
    else $error("request stalled without a held response");

  // A decoded request always lands in the output register
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> rsp_valid)
    else $error("decoded request lost");

  // An acknowledged line is clear in its response
  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_req.opcode == OP_ACK) |=>
      ((rsp.irq_lines & (8'h01 << $past(s1_req.ack_line))) == 8'h00))
    else $error("acknowledged line still pending");

endmodule

`default_nettype wire
